[rtl/msl_pkg.sv]
package msl_pkg;

	localparam int LIST_LEN_W = 16;
	localparam int BYTE_W     = 8;
	localparam int SECTOR_W   = 16;

	// Request kinds
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_DATA  = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_LEN_ERR   = 2'd1,
		STATUS_FIELD_ERR = 2'd2
	} status_t;

	localparam logic [SECTOR_W-1:0] SECTOR_RESET = 16'd512;

	// Mode parameter header lengths for the two command forms
	localparam logic [LIST_LEN_W-1:0] HDR_LONG  = 16'd8;
	localparam logic [LIST_LEN_W-1:0] HDR_SHORT = 16'd4;
	// Offset of the block size's low byte from the end of the header
	localparam logic [LIST_LEN_W-1:0] BLK_SIZE_LO = 16'd7;
	// Length of one block descriptor
	localparam logic [LIST_LEN_W-1:0] DESC_LEN = 16'd8;

	localparam logic [BYTE_W-1:0] PAGE_ERR_RECOVERY = 8'h01;
	localparam logic [BYTE_W-1:0] PAGE_FORMAT_DEV   = 8'h03;
	localparam logic [BYTE_W-1:0] PAGE_VERIFY_ERR   = 8'h07;

	localparam logic [LIST_LEN_W-1:0] MIN_REM_ERR_RECOVERY = 16'd10;
	localparam logic [LIST_LEN_W-1:0] MIN_REM_FORMAT_DEV   = 16'd22;
	localparam logic [LIST_LEN_W-1:0] MIN_REM_VERIFY_ERR   = 16'd6;

	// One less than the bytes from a format page's code byte to the low byte of its sector size
	localparam int SECT_CHECK_DELAY = 12;
	localparam int DUE_W            = SECT_CHECK_DELAY + 1;

	typedef struct packed {
		logic                  req_type;
		logic                  ten_byte_form;
		logic                  page_format;
		logic [LIST_LEN_W-1:0] list_length;
		logic [BYTE_W-1:0]     data_byte;
	} item_t;

	typedef struct packed {
		logic    valid;
		status_t status;
	} res_t;

endpackage

[rtl/msl_if.sv]
interface msl_item_if import msl_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  req_type;
	logic                  ten_byte_form;
	logic                  page_format;
	logic [LIST_LEN_W-1:0] list_length;
	logic [BYTE_W-1:0]     data_byte;

	modport source (output valid, req_type, ten_byte_form, page_format, list_length,
		data_byte, input ready);
	modport sink (input valid, req_type, ten_byte_form, page_format, list_length,
		data_byte, output ready);
endinterface

interface msl_result_if import msl_pkg::*; ();
	logic    valid;
	logic    ready;
	status_t status;

	modport source (output valid, status, input ready);
	modport sink (input valid, status, output ready);
endinterface

interface msl_cfg_if import msl_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SECTOR_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

[rtl/msl_parse.sv]
module msl_parse import msl_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  item_t               item,
	input  logic [SECTOR_W-1:0] blk_bytes,
	output res_t                res
);

	logic [LIST_LEN_W-1:0] pos_q, pos_n;
	logic [LIST_LEN_W-1:0] tl_q, tl_n;
	logic                  long_q, long_n;
	logic                  fmt_q, fmt_n;
	logic [LIST_LEN_W-1:0] ps_q, ps_n;
	logic [BYTE_W-1:0]     hb_q, hb_n;
	status_t               pend_q, pend_n;
	logic                  done_q, done_n;
	logic                  walk_q, walk_n;
	logic                  desc_q, desc_n;
	logic                  ovr_q, ovr_n;
	logic [DUE_W-1:0]      due_q, due_n;

	logic [BYTE_W-1:0]     b;
	logic [SECTOR_W-1:0]   pair;
	logic [LIST_LEN_W-1:0] hdr;
	logic [LIST_LEN_W-1:0] hdr_start;
	logic [LIST_LEN_W-1:0] dl;
	logic [LIST_LEN_W:0]   hdr_dl;
	logic [LIST_LEN_W:0]   next_ps;
	logic [LIST_LEN_W-1:0] rem;

	always_comb begin
		b         = item.data_byte;
		pair      = {hb_q, b};
		hdr       = long_q ? HDR_LONG : HDR_SHORT;
		hdr_start = item.ten_byte_form ? HDR_LONG : HDR_SHORT;
		dl        = long_q ? pair : {{(LIST_LEN_W-BYTE_W){1'b0}}, b};
		hdr_dl    = {1'b0, hdr} + {1'b0, dl};
		next_ps   = {1'b0, ps_q} + {{(LIST_LEN_W-BYTE_W+1){1'b0}}, b} + 17'd2;
		rem       = tl_q - pos_q;

		pos_n  = pos_q;
		tl_n   = tl_q;
		long_n = long_q;
		fmt_n  = fmt_q;
		ps_n   = ps_q;
		hb_n   = hb_q;
		pend_n = pend_q;
		done_n = done_q;
		walk_n = walk_q;
		desc_n = desc_q;
		ovr_n  = ovr_q;
		due_n  = due_q;
		res.valid  = 1'b0;
		res.status = STATUS_OK;

		if (step_en) begin
			if (item.req_type == REQ_START) begin
				long_n = item.ten_byte_form;
				fmt_n  = item.page_format;
				tl_n   = item.list_length;
				pos_n  = '0;
				ps_n   = '0;
				hb_n   = '0;
				walk_n = 1'b0;
				desc_n = 1'b0;
				ovr_n  = 1'b0;
				due_n  = '0;
				pend_n = STATUS_OK;
				if (item.list_length == '0) begin
					done_n    = 1'b1;
					res.valid = 1'b1;
				end else begin
					done_n = 1'b0;
					if (item.page_format && item.list_length < hdr_start)
						pend_n = STATUS_LEN_ERR;
				end
			end else if (!done_q) begin
				if (fmt_q) begin
					// A format page's sector size completes on this byte.
					if (due_q[0] && pair != blk_bytes)
						ovr_n = 1'b1;
					due_n = {1'b0, due_q[DUE_W-1:1]};

					// Last header byte: descriptor length is known.
					if (pend_q == STATUS_OK && !walk_q && !desc_q && pos_q == hdr - 16'd1) begin
						if ({1'b0, tl_q} < hdr_dl) begin
							pend_n = STATUS_LEN_ERR;
						end else begin
							desc_n = (dl != '0) && (tl_q >= hdr + DESC_LEN);
							ps_n   = hdr_dl[LIST_LEN_W-1:0];
							walk_n = hdr_dl[LIST_LEN_W-1:0] < tl_q;
						end
					end

					if (desc_q && pos_q == hdr + BLK_SIZE_LO) begin
						desc_n = 1'b0;
						if (pair != blk_bytes)
							ovr_n = 1'b1;
					end

					// The header step above never fires together with the page walk.
					if (walk_q && pend_q == STATUS_OK) begin
						if (pos_q == ps_q) begin
							case (b)
								PAGE_ERR_RECOVERY: begin
									if (rem < MIN_REM_ERR_RECOVERY)
										pend_n = STATUS_LEN_ERR;
								end
								PAGE_FORMAT_DEV: begin
									if (rem < MIN_REM_FORMAT_DEV)
										pend_n = STATUS_LEN_ERR;
									else
										due_n[DUE_W-1] = 1'b1;
								end
								PAGE_VERIFY_ERR: begin
									if (rem < MIN_REM_VERIFY_ERR)
										pend_n = STATUS_LEN_ERR;
								end
								default: begin
									pend_n = STATUS_FIELD_ERR;
								end
							endcase
							if (pend_n != STATUS_OK)
								walk_n = 1'b0;
						end else if ({1'b0, pos_q} == {1'b0, ps_q} + 17'd1) begin
							if (next_ps >= {1'b0, tl_q})
								walk_n = 1'b0;
							else
								ps_n = next_ps[LIST_LEN_W-1:0];
						end
					end
					hb_n = b;
				end

				pos_n = pos_q + 16'd1;
				if (pos_n == tl_q) begin
					done_n     = 1'b1;
					res.valid  = 1'b1;
					res.status = ovr_n ? STATUS_FIELD_ERR : pend_n;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			tl_q   <= '0;
			long_q <= 1'b0;
			fmt_q  <= 1'b0;
			ps_q   <= '0;
			hb_q   <= '0;
			pend_q <= STATUS_OK;
			done_q <= 1'b1;
			walk_q <= 1'b0;
			desc_q <= 1'b0;
			ovr_q  <= 1'b0;
			due_q  <= '0;
		end else begin
			pos_q  <= pos_n;
			tl_q   <= tl_n;
			long_q <= long_n;
			fmt_q  <= fmt_n;
			ps_q   <= ps_n;
			hb_q   <= hb_n;
			pend_q <= pend_n;
			done_q <= done_n;
			walk_q <= walk_n;
			desc_q <= desc_n;
			ovr_q  <= ovr_n;
			due_q  <= due_n;
		end
	end

endmodule

[rtl/mode_select_list_checker_core.sv]
// Channel | Dir | Payload                                               | Word
// item    | in  | req_type, ten_byte_form, page_format, list_length,    | start or list byte
//         |     | data_byte                                             |
// result  | out | status                                                | one per command
// cfg     | in  | data (sector size)                                    | register write
//
// One word is accepted per cycle. A word is registered on acceptance and checked against the
// parser state when the output register is free to take its status; any status lands in the
// output register as the word is checked, and is offered from there.
// Reset restores a sector size of 512 and leaves the parser idle.
// A stalled output register holds the input register; input ready then falls.
module mode_select_list_checker_core import msl_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	msl_item_if.sink   item,
	msl_result_if.source result,
	msl_cfg_if.sink    cfg
);

	logic                valid_s1;
	item_t               item_s1;
	logic                out_valid_q;
	status_t             out_status_q;
	logic [SECTOR_W-1:0] sector_q;
	logic                out_free;
	logic                advance;
	logic                in_accept;
	res_t                res;

	assign out_free  = !out_valid_q || result.ready;
	assign advance   = valid_s1 && out_free;
	assign item.ready = !valid_s1 || out_free;
	assign in_accept = item.valid && item.ready;
	assign cfg.ready = 1'b1;

	assign result.valid  = out_valid_q;
	assign result.status = out_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sector_q <= SECTOR_RESET;
		end else if (cfg.valid) begin
			sector_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1.req_type      <= item.req_type;
			item_s1.ten_byte_form <= item.ten_byte_form;
			item_s1.page_format   <= item.page_format;
			item_s1.list_length   <= item.list_length;
			item_s1.data_byte     <= item.data_byte;
		end
	end

	msl_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (advance),
		.item      (item_s1),
		.blk_bytes (sector_q),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			out_status_q <= res.status;
		end
	end

endmodule
